FILE: sv/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg - shared types and helpers of the vector fixed point alu
// widths, operation classes, transaction structs, rounding and clamping
// ----------------------------------------------------------------------------
package vfa_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;

	localparam int PROD_W  = 2 * DATA_W;
	localparam int TRUNC_W = PROD_W - FRAC_W;
	localparam int WIDE_W  = (TRUNC_W + 2 > DATA_W + 2) ? TRUNC_W + 2 : DATA_W + 2;
	localparam int SUM_W   = 2 * DATA_W;
	localparam int ROOT_W  = DATA_W;
	localparam int NUM_W   = DATA_W + FRAC_W;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// accept edge to result edge
	localparam int LATENCY = 5 + ROOT_W + NUM_W;

	typedef logic signed [DATA_W-1:0] word_t;

	localparam word_t VMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t VMIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_SCALE = 4'd3,
		OP_DIV   = 4'd4,
		OP_DOT   = 4'd5,
		OP_CROSS = 4'd6,
		OP_LEN   = 4'd7,
		OP_NORM  = 4'd8,
		OP_NOP   = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0] operation;
		word_t      ax;
		word_t      ay;
		word_t      az;
		word_t      bx;
		word_t      by_comp;
		word_t      bz;
		word_t      scalar_in;
	} in_item_t;

	typedef struct packed {
		word_t      rx;
		word_t      ry;
		word_t      rz;
		word_t      scalar_out;
		logic [1:0] status;
	} out_item_t;

	// classified command between front and back
	typedef struct packed {
		op_t         op;
		word_t [2:0] a;
		word_t [2:0] b;
		word_t       s;
		logic        div0;
	} cmd_t;

	// product truncated toward zero, fraction bits dropped
	function automatic logic signed [TRUNC_W-1:0] trunc_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] biased;
		logic signed [PROD_W-1:0] shifted;
		biased  = p + (p[PROD_W-1] ? PROD_W'({FRAC_W{1'b1}}) : PROD_W'(0));
		shifted = biased >>> FRAC_W;
		return shifted[TRUNC_W-1:0];
	endfunction

	// clamp to the data range, msb of the result is the saturation flag
	function automatic logic [DATA_W:0] clamp_w(input logic signed [WIDE_W-1:0] v);
		if (v > WIDE_W'(VMAX))
			return {1'b1, VMAX};
		if (v < WIDE_W'(VMIN))
			return {1'b1, VMIN};
		return {1'b0, v[DATA_W-1:0]};
	endfunction

endpackage

FILE: sv/vfa_front.sv
// ----------------------------------------------------------------------------
// vfa_front - command intake
// takes transactions, classifies the operation code and hands them to the queue
// ----------------------------------------------------------------------------
module vfa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  vfa_pkg::in_item_t item,
	input  logic              q_full,
	output logic              busy,
	output logic              push,
	output vfa_pkg::cmd_t     cmd
);
	import vfa_pkg::*;

	logic     v_s1;
	in_item_t item_s1;
	logic     accept;

	assign busy   = v_s1 && q_full;
	assign push   = v_s1 && !q_full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// unknown codes fall to a no-op class
	always_comb begin
		cmd.a[0] = item_s1.ax;
		cmd.a[1] = item_s1.ay;
		cmd.a[2] = item_s1.az;
		cmd.b[0] = item_s1.bx;
		cmd.b[1] = item_s1.by_comp;
		cmd.b[2] = item_s1.bz;
		cmd.s    = item_s1.scalar_in;
		cmd.div0 = (item_s1.scalar_in == '0);
		unique case (item_s1.operation)
			OP_ADD:   cmd.op = OP_ADD;
			OP_SUB:   cmd.op = OP_SUB;
			OP_NEG:   cmd.op = OP_NEG;
			OP_SCALE: cmd.op = OP_SCALE;
			OP_DIV:   cmd.op = OP_DIV;
			OP_DOT:   cmd.op = OP_DOT;
			OP_CROSS: cmd.op = OP_CROSS;
			OP_LEN:   cmd.op = OP_LEN;
			OP_NORM:  cmd.op = OP_NORM;
			default:  cmd.op = OP_NOP;
		endcase
	end

endmodule

FILE: sv/vfa_queue.sv
// ----------------------------------------------------------------------------
// vfa_queue - short command queue
// decouples the intake from the execution pipeline
// ----------------------------------------------------------------------------
module vfa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vfa_pkg::cmd_t wdata,
	input  logic          pop,
	output logic          full,
	output logic          avail,
	output vfa_pkg::cmd_t rdata
);
	import vfa_pkg::*;

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign avail   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && avail;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/vfa_div.sv
// ----------------------------------------------------------------------------
// vfa_div - pipelined restoring divider lane
// one quotient bit per stage, unsigned magnitudes
// ----------------------------------------------------------------------------
module vfa_div (
	input  logic                       clk,
	input  logic [vfa_pkg::NUM_W-1:0]  num,
	input  logic [vfa_pkg::DATA_W-1:0] den,
	output logic [vfa_pkg::NUM_W-1:0]  quo
);
	import vfa_pkg::*;

	logic [NUM_W-1:0]  nq_s  [NUM_W];
	logic [DATA_W-1:0] rem_s [NUM_W];
	logic [DATA_W-1:0] den_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [NUM_W-1:0]  nq_i;
		logic [DATA_W-1:0] rem_i;
		logic [DATA_W-1:0] den_i;
		logic [DATA_W:0]   acc;
		logic              ge;

		if (k == 0) begin : g_first
			assign nq_i  = num;
			assign rem_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign nq_i  = nq_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
		end

		assign acc = {rem_i, nq_i[NUM_W-1]};
		assign ge  = (acc >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			nq_s[k]  <= {nq_i[NUM_W-2:0], ge};
			rem_s[k] <= ge ? DATA_W'(acc - {1'b0, den_i}) : acc[DATA_W-1:0];
			den_s[k] <= den_i;
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

FILE: sv/vfa_back.sv
// ----------------------------------------------------------------------------
// vfa_back - execution pipeline
// multiply, truncate and clamp, square root stages, divider stages, result
// ----------------------------------------------------------------------------
module vfa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_v,
	input  vfa_pkg::cmd_t      cmd,
	output logic               done,
	output vfa_pkg::out_item_t result
);
	import vfa_pkg::*;

	typedef struct packed {
		op_t         op;
		logic        div0;
		word_t [2:0] r;
		word_t       sc;
		logic        sat;
		logic [2:0]  neg;
		logic [2:0]  nz;
		logic        sneg;
	} meta_t;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] num;
		logic [DATA_W-1:0]     smag;
	} side_t;

	localparam int VP_W = 2 + ROOT_W + NUM_W;
	localparam logic [NUM_W-1:0] QPOS = NUM_W'(VMAX);
	localparam logic [NUM_W-1:0] QNEG = QPOS + 1'b1;

	function automatic logic [DATA_W:0] q_clamp(input logic [NUM_W-1:0] q, input logic neg);
		if (!neg) begin
			if (q > QPOS)
				return {1'b1, VMAX};
			return {1'b0, q[DATA_W-1:0]};
		end
		if (q > QNEG)
			return {1'b1, VMIN};
		return {1'b0, DATA_W'(~q[DATA_W-1:0] + 1'b1)};
	endfunction

	logic [VP_W-1:0] vpipe_q;

	// stage 1: operand select and products
	word_t                    ma [6];
	word_t                    mb [6];
	logic signed [PROD_W-1:0] mp [6];
	logic signed [PROD_W-1:0] p_s1 [6];
	cmd_t                     cmd_s1;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ma[k] = '0;
			mb[k] = '0;
		end
		unique case (cmd.op) inside
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = cmd.a[i];
					mb[i] = cmd.s;
				end
			end
			OP_DOT: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = cmd.a[i];
					mb[i] = cmd.b[i];
				end
			end
			OP_CROSS: begin
				ma[0] = cmd.a[1]; mb[0] = cmd.b[2];
				ma[1] = cmd.a[2]; mb[1] = cmd.b[1];
				ma[2] = cmd.a[2]; mb[2] = cmd.b[0];
				ma[3] = cmd.a[0]; mb[3] = cmd.b[2];
				ma[4] = cmd.a[0]; mb[4] = cmd.b[1];
				ma[5] = cmd.a[1]; mb[5] = cmd.b[0];
			end
			OP_LEN, OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = cmd.a[i];
					mb[i] = cmd.a[i];
				end
			end
			default: ;
		endcase
		for (int k = 0; k < 6; k++) begin
			mp[k] = PROD_W'(ma[k]) * PROD_W'(mb[k]);
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		for (int k = 0; k < 6; k++) begin
			p_s1[k] <= mp[k];
		end
	end

	// stage 2: truncation, sums, clamps, operand prep for root and divide
	word_t                     av [3];
	word_t                     bv [3];
	logic signed [TRUNC_W-1:0] t  [6];
	logic signed [WIDE_W-1:0]  w  [3];
	logic signed [WIDE_W-1:0]  ws;
	logic [DATA_W:0]           cw [3];
	logic [DATA_W:0]           cs;
	logic [DATA_W-1:0]         amag [3];
	meta_t                     meta_c;
	side_t                     side_c;
	logic [SUM_W-1:0]          sq_c;
	meta_t                     meta_s2;
	side_t                     side_s2;
	logic [SUM_W-1:0]          sq_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			av[i] = cmd_s1.a[i];
			bv[i] = cmd_s1.b[i];
			w[i]  = '0;
		end
		for (int k = 0; k < 6; k++) begin
			t[k] = trunc_prod(p_s1[k]);
		end
		ws = '0;
		unique case (cmd_s1.op)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) w[i] = WIDE_W'(av[i]) + WIDE_W'(bv[i]);
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) w[i] = WIDE_W'(av[i]) - WIDE_W'(bv[i]);
			end
			OP_NEG: begin
				for (int i = 0; i < 3; i++) w[i] = -WIDE_W'(av[i]);
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) w[i] = WIDE_W'(t[i]);
			end
			OP_DOT: begin
				ws = WIDE_W'(t[0]) + WIDE_W'(t[1]) + WIDE_W'(t[2]);
			end
			OP_CROSS: begin
				w[0] = WIDE_W'(t[0]) - WIDE_W'(t[1]);
				w[1] = WIDE_W'(t[2]) - WIDE_W'(t[3]);
				w[2] = WIDE_W'(t[4]) - WIDE_W'(t[5]);
			end
			default: ;
		endcase
		cs = clamp_w(ws);
		for (int i = 0; i < 3; i++) begin
			cw[i]         = clamp_w(w[i]);
			amag[i]       = av[i][DATA_W-1] ? DATA_W'(-av[i]) : DATA_W'(av[i]);
			meta_c.r[i]   = cw[i][DATA_W-1:0];
			meta_c.neg[i] = av[i][DATA_W-1];
			meta_c.nz[i]  = (av[i] != '0);
			side_c.num[i] = {amag[i], {FRAC_W{1'b0}}};
		end
		meta_c.op   = cmd_s1.op;
		meta_c.div0 = cmd_s1.div0;
		meta_c.sc   = cs[DATA_W-1:0];
		meta_c.sat  = cw[0][DATA_W] | cw[1][DATA_W] | cw[2][DATA_W] | cs[DATA_W];
		meta_c.sneg = cmd_s1.s[DATA_W-1];
		side_c.smag = cmd_s1.s[DATA_W-1] ? DATA_W'(-cmd_s1.s) : DATA_W'(cmd_s1.s);
		sq_c = $unsigned(p_s1[0]) + $unsigned(p_s1[1]) + $unsigned(p_s1[2]);
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta_c;
		side_s2 <= side_c;
		sq_s2   <= sq_c;
	end

	// square root stages, one root bit each
	logic [SUM_W-1:0]  rt_rad_s  [ROOT_W];
	logic [ROOT_W+1:0] rt_rem_s  [ROOT_W];
	logic [ROOT_W-1:0] rt_root_s [ROOT_W];
	meta_t             rt_meta_s [ROOT_W];
	side_t             rt_side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [SUM_W-1:0]  rad_i;
		logic [ROOT_W+1:0] rem_i;
		logic [ROOT_W-1:0] root_i;
		meta_t             meta_i;
		side_t             side_i;
		logic [ROOT_W+1:0] acc;
		logic [ROOT_W+1:0] trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_i  = sq_s2;
			assign rem_i  = '0;
			assign root_i = '0;
			assign meta_i = meta_s2;
			assign side_i = side_s2;
		end else begin : g_next
			assign rad_i  = rt_rad_s[k-1];
			assign rem_i  = rt_rem_s[k-1];
			assign root_i = rt_root_s[k-1];
			assign meta_i = rt_meta_s[k-1];
			assign side_i = rt_side_s[k-1];
		end

		assign acc   = {rem_i[ROOT_W-1:0], rad_i[SUM_W-1 -: 2]};
		assign trial = {root_i, 2'b01};
		assign ge    = (acc >= trial);

		always_ff @(posedge clk) begin
			rt_rad_s[k]  <= rad_i << 2;
			rt_rem_s[k]  <= ge ? acc - trial : acc;
			rt_root_s[k] <= {root_i[ROOT_W-2:0], ge};
			rt_meta_s[k] <= meta_i;
			rt_side_s[k] <= side_i;
		end
	end

	// divider stages, three lanes plus side data
	logic [ROOT_W-1:0] len_c;
	logic [DATA_W-1:0] den_c;
	logic [NUM_W-1:0]  quo [3];
	meta_t             dv_meta_s [NUM_W];
	logic [ROOT_W-1:0] dv_len_s  [NUM_W];

	assign len_c = rt_root_s[ROOT_W-1];
	assign den_c = (rt_meta_s[ROOT_W-1].op == OP_DIV) ? rt_side_s[ROOT_W-1].smag : len_c;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vfa_div u_div (
			.clk (clk),
			.num (rt_side_s[ROOT_W-1].num[i]),
			.den (den_c),
			.quo (quo[i])
		);
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_dmeta
		always_ff @(posedge clk) begin
			if (k == 0) begin
				dv_meta_s[k] <= rt_meta_s[ROOT_W-1];
				dv_len_s[k]  <= len_c;
			end else begin
				dv_meta_s[k] <= dv_meta_s[(k == 0) ? 0 : k-1];
				dv_len_s[k]  <= dv_len_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	// result assembly
	meta_t             fm;
	logic [ROOT_W-1:0] flen;
	logic [DATA_W:0]   qc [3];
	word_t             rv [3];
	word_t             scv;
	logic              satv;
	logic [1:0]        stv;
	out_item_t         res_c;
	out_item_t         result_q;
	logic              done_q;

	assign fm   = dv_meta_s[NUM_W-1];
	assign flen = dv_len_s[NUM_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rv[i] = fm.r[i];
			qc[i] = q_clamp(quo[i], fm.neg[i] ^ ((fm.op == OP_DIV) && fm.sneg));
		end
		scv  = fm.sc;
		satv = fm.sat;
		stv  = ST_OK;
		unique case (fm.op)
			OP_DIV: begin
				if (fm.div0) begin
					for (int i = 0; i < 3; i++)
						rv[i] = fm.nz[i] ? (fm.neg[i] ? VMIN : VMAX) : '0;
					stv = ST_DIV0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						rv[i] = qc[i][DATA_W-1:0];
						satv  = satv | qc[i][DATA_W];
					end
				end
			end
			OP_NORM: begin
				if (flen != '0) begin
					for (int i = 0; i < 3; i++) begin
						rv[i] = qc[i][DATA_W-1:0];
						satv  = satv | qc[i][DATA_W];
					end
				end
			end
			OP_LEN: begin
				if (flen[ROOT_W-1]) begin
					scv  = VMAX;
					satv = 1'b1;
				end else begin
					scv = DATA_W'(flen);
				end
			end
			default: ;
		endcase
		if (stv != ST_DIV0 && satv)
			stv = ST_SAT;
		res_c.rx         = rv[0];
		res_c.ry         = rv[1];
		res_c.rz         = rv[2];
		res_c.scalar_out = scv;
		res_c.status     = stv;
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpipe_q <= '0;
			done_q  <= 1'b0;
		end else begin
			vpipe_q <= {vpipe_q[VP_W-2:0], pop_v};
			done_q  <= vpipe_q[VP_W-1];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: sv/vector3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu - three component vector alu, signed fixed point
// the accepted transaction passes the intake register, the queue, the product and sum
// stages, the square root and divider stages and the result register (Q16.16 data)
// throughput: one transaction per cycle, busy stays low since the back end
// never stalls
// reset: asynchronous, clears the valid pipeline, queue and intake state
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vfa_pkg::in_item_t  item,
	output logic               done,
	output vfa_pkg::out_item_t result
);
	import vfa_pkg::*;

	// front to queue
	logic q_full;
	logic q_push;
	cmd_t q_wdata;

	// queue to back
	logic q_avail;
	cmd_t q_rdata;

	// intake: registers the transaction and classifies the operation
	vfa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.push   (q_push),
		.cmd    (q_wdata)
	);

	// two entry queue between intake and execution
	vfa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_avail),
		.full   (q_full),
		.avail  (q_avail),
		.rdata  (q_rdata)
	);

	// execution pipeline takes one command every cycle it is offered
	vfa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pop_v  (q_avail),
		.cmd    (q_rdata),
		.done   (done),
		.result (result)
	);

endmodule

FILE: sv/vfa_checker.sv
// ----------------------------------------------------------------------------
// vfa_checker - port level checks of the vector alu
// latency, no back pressure, and result field consistency
// ----------------------------------------------------------------------------
module vfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input vfa_pkg::out_item_t result
);
	import vfa_pkg::*;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline never stalls");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a transaction at the expected latency");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_SAT
			|| result.status == ST_DIV0))
		else $error("undefined status code");

	a_div0_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_DIV0 |-> result.scalar_out == '0)
		else $error("divide by zero with a scalar result");

	a_scalar_vec: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.scalar_out != '0 |->
			result.rx == '0 && result.ry == '0 && result.rz == '0)
		else $error("scalar and vector result both nonzero");

endmodule

bind vector3_fixed_point_alu vfa_checker u_chk (.*);

FILE: verif/vector3_fixed_point_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_tb - self-checking bench of the vector fixed point alu
// a table of directed transactions and random ones are sent with random gaps;
// every result is compared per field to typed rows or a behavioral predictor
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_tb;
	import vfa_pkg::*;

	localparam int N_RANDOM   = 500;
	localparam int DRAIN_CYC  = 200;
	localparam longint LIMIT  = 400000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;

	// directed row: stimulus, and an expectation when typed in by hand
	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	out_item_t alu_expected[$];
	bit        failed = 1'b0;
	longint    cycle_cnt = 0;

	vector3_fixed_point_alu i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// -------------------------------------------------------------------------
	// predictor, done in wide signed integers
	// -------------------------------------------------------------------------
	function automatic longint clamp32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// product truncated toward zero; |a*b| <= 2^62 fits in 64 bits
	function automatic longint qmul(input longint a, input longint b);
		longint p;
		p = a * b;
		if (p < 0)
			return -((-p) >>> FRAC_W);
		return p >>> FRAC_W;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic out_item_t vector_alu_predict(input in_item_t t);
		longint      a[3];
		longint      b[3];
		longint      r[3];
		longint      s;
		longint      sc;
		bit          sat;
		logic [1:0]  st;
		logic [63:0] sum;
		logic [63:0] len;
		logic [63:0] m;
		out_item_t   o;
		a[0] = longint'(t.ax);
		a[1] = longint'(t.ay);
		a[2] = longint'(t.az);
		b[0] = longint'(t.bx);
		b[1] = longint'(t.by_comp);
		b[2] = longint'(t.bz);
		s    = longint'(t.scalar_in);
		r    = '{0, 0, 0};
		sc   = 0;
		sat  = 1'b0;
		st   = ST_OK;
		case (t.operation)
			OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], sat);
			OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], sat);
			OP_NEG: for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i], sat);
			OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32(qmul(a[i], s), sat);
			OP_DIV: begin
				if (s == 0) begin
					// divide by zero: sign of the component picks the bound
					for (int i = 0; i < 3; i++)
						r[i] = a[i] > 0 ? 64'sd2147483647 :
							(a[i] < 0 ? -64'sd2147483648 : 0);
					st = ST_DIV0;
				end else begin
					for (int i = 0; i < 3; i++)
						r[i] = clamp32((a[i] <<< FRAC_W) / s, sat);
				end
			end
			OP_DOT: sc = clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]), sat);
			OP_CROSS: begin
				r[0] = clamp32(qmul(a[1], b[2]) - qmul(a[2], b[1]), sat);
				r[1] = clamp32(qmul(a[2], b[0]) - qmul(a[0], b[2]), sat);
				r[2] = clamp32(qmul(a[0], b[1]) - qmul(a[1], b[0]), sat);
			end
			OP_LEN, OP_NORM: begin
				sum = '0;
				for (int i = 0; i < 3; i++) begin
					m   = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
					sum = sum + m * m;
				end
				len = floor_sqrt(sum);
				if (t.operation == OP_LEN) begin
					if (len > 64'd2147483647) begin
						sat = 1'b1;
						sc  = 64'sd2147483647;
					end else begin
						sc = longint'(len);
					end
				end else if (len == 0) begin
					// zero vector comes back unchanged
					for (int i = 0; i < 3; i++) r[i] = a[i];
				end else begin
					for (int i = 0; i < 3; i++)
						r[i] = clamp32((a[i] <<< FRAC_W) / longint'(len), sat);
				end
			end
			default: ;
		endcase
		if (st == ST_OK && sat)
			st = ST_SAT;
		o.rx         = word_t'(r[0]);
		o.ry         = word_t'(r[1]);
		o.rz         = word_t'(r[2]);
		o.scalar_out = word_t'(sc);
		o.status     = st;
		return o;
	endfunction

	// -------------------------------------------------------------------------
	// stimulus helpers
	// -------------------------------------------------------------------------
	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0: return VMAX;
			1: return VMIN;
			2: return '0;
			3: return word_t'($urandom_range(0, 8)) <<< FRAC_W;
			4: return -(word_t'($urandom_range(0, 8)) <<< FRAC_W);
			5, 6: return word_t'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t mk(input logic [3:0] op, input word_t ax, input word_t ay,
			input word_t az, input word_t bx, input word_t by, input word_t bz,
			input word_t s);
		in_item_t t;
		t.operation = op;
		t.ax        = ax;
		t.ay        = ay;
		t.az        = az;
		t.bx        = bx;
		t.by_comp   = by;
		t.bz        = bz;
		t.scalar_in = s;
		return t;
	endfunction

	function automatic out_item_t mkr(input word_t rx, input word_t ry, input word_t rz,
			input word_t sc, input logic [1:0] st);
		out_item_t o;
		o.rx         = rx;
		o.ry         = ry;
		o.rz         = rz;
		o.scalar_out = sc;
		o.status     = st;
		return o;
	endfunction

	// one transaction: wait a random gap, hold start until the accepting edge
	task automatic send_item(input in_item_t t, input bit typed, input out_item_t want);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item  <= t;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		alu_expected.push_back(typed ? want : vector_alu_predict(t));
		@(negedge clk);
	endtask

	// -------------------------------------------------------------------------
	// result checker, sampled at the rising edge
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && done) begin
			if (alu_expected.size() == 0) begin
				failed = 1'b1;
				$display("%0t unexpected result %p", $realtime, result);
			end else begin
				w = alu_expected.pop_front();
				if (result.rx !== w.rx || result.ry !== w.ry || result.rz !== w.rz ||
						result.scalar_out !== w.scalar_out || result.status !== w.status) begin
					failed = 1'b1;
					$display("%0t mismatch expected %p actual %p", $realtime, w, result);
				end
			end
		end
	end

	// watchdog on the cycle count
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// main sequence
	// -------------------------------------------------------------------------
	initial begin
		dir_row_t  rows[$];
		in_item_t  t;
		out_item_t nochk;
		word_t     one;
		int        wait_cnt;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		nochk     = '0;
		one       = word_t'(1) <<< FRAC_W;

		// extremes and special cases, typed where obvious
		rows.push_back('{mk(OP_ADD, VMAX, VMIN, 0, 1, -1, 0, 0), 1,
			mkr(VMAX, VMIN, 0, 0, ST_SAT)});
		rows.push_back('{mk(OP_SUB, VMIN, VMAX, 5, 1, -1, 5, 0), 1,
			mkr(VMIN, VMAX, 0, 0, ST_SAT)});
		rows.push_back('{mk(OP_NEG, VMIN, VMAX, 0, 0, 0, 0, 0), 1,
			mkr(VMAX, -VMAX, 0, 0, ST_SAT)});
		rows.push_back('{mk(OP_DIV, VMAX, VMIN, 0, 0, 0, 0, 0), 1,
			mkr(VMAX, VMIN, 0, 0, ST_DIV0)});
		rows.push_back('{mk(OP_DIV, -one, one, 0, 7, 7, 7, 0), 1,
			mkr(VMIN, VMAX, 0, 0, ST_DIV0)});
		rows.push_back('{mk(OP_NORM, 0, 0, 0, 3, 3, 3, 3), 1, mkr(0, 0, 0, 0, ST_OK)});
		rows.push_back('{mk(4'd9, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX), 1,
			mkr(0, 0, 0, 0, ST_OK)});
		rows.push_back('{mk(4'd15, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN), 1,
			mkr(0, 0, 0, 0, ST_OK)});
		rows.push_back('{mk(OP_LEN, VMIN, VMIN, VMIN, 0, 0, 0, 0), 1,
			mkr(0, 0, 0, VMAX, ST_SAT)});
		rows.push_back('{mk(OP_LEN, 3 * one, 4 * one, 0, 0, 0, 0, 0), 1,
			mkr(0, 0, 0, 5 * one, ST_OK)});
		// predictor-checked rows
		rows.push_back('{mk(OP_SCALE, VMAX, VMIN, -3, 0, 0, 0, VMIN), 0, nochk});
		rows.push_back('{mk(OP_SCALE, 3, -3, one, 0, 0, 0, -32'sd1), 0, nochk});
		rows.push_back('{mk(OP_DIV, VMIN, VMAX, 1, 0, 0, 0, -32'sd1), 0, nochk});
		rows.push_back('{mk(OP_DIV, 7, -7, one, 0, 0, 0, 3 * one), 0, nochk});
		rows.push_back('{mk(OP_DOT, VMAX, VMIN, VMAX, VMAX, VMIN, VMAX, 0), 0, nochk});
		rows.push_back('{mk(OP_DOT, -1, 1, one, 1, -1, -one, 0), 0, nochk});
		rows.push_back('{mk(OP_CROSS, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, 0), 0, nochk});
		rows.push_back('{mk(OP_CROSS, one, 0, 0, 0, one, 0, 0), 0, nochk});
		rows.push_back('{mk(OP_NORM, VMIN, VMAX, 1, 0, 0, 0, 0), 0, nochk});
		rows.push_back('{mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0), 0, nochk});
		rows.push_back('{mk(OP_NORM, -3 * one, 4 * one, 0, 0, 0, 0, 0), 0, nochk});
		rows.push_back('{mk(OP_LEN, 1, -1, 1, 0, 0, 0, 0), 0, nochk});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_item(rows[i].stim, rows[i].typed, rows[i].want);

		// random part, mostly legal codes with some unknown ones
		for (int n = 0; n < N_RANDOM; n++) begin
			t = mk($urandom_range(0, 15) == 0 ? 4'($urandom_range(9, 15))
					: 4'($urandom_range(0, 8)),
				rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word(), $urandom_range(0, 7) == 0 ? word_t'(0) : rand_word());
			send_item(t, 1'b0, nochk);
		end
		start <= 1'b0;

		// drain everything in flight, then a quiet tail for stray results
		wait_cnt = 0;
		while (alu_expected.size() != 0 && wait_cnt < 10 * LATENCY + 1000) begin
			@(posedge clk);
			wait_cnt++;
		end
		if (alu_expected.size() != 0)
			$display("%0t %0d results never arrived", $realtime, alu_expected.size());
		repeat (DRAIN_CYC) @(posedge clk);

		if (!failed && alu_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
sv/vfa_pkg.sv
sv/vfa_front.sv
sv/vfa_queue.sv
sv/vfa_div.sv
sv/vfa_back.sv
sv/vector3_fixed_point_alu.sv
sv/vfa_checker.sv
verif/vector3_fixed_point_alu_tb.sv
